/* rtl/relative_power_squelch_top_defines.svh */
// Assertion macros for the relative power squelch.
`ifndef RELATIVE_POWER_SQUELCH_TOP_DEFINES_SVH
`define RELATIVE_POWER_SQUELCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relative_power_squelch: check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define RPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relative_power_squelch: check failed");

`endif

/* rtl/rps_pkg.sv */
// Shared constants and types for the relative power squelch.
package rps_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GAIN_BITS_DEF   = 16;

    localparam int SETTLE_BITS     = 17;
    localparam int RATIO_BITS      = 16;
    localparam int RATIO_FRAC      = 8;
    localparam int OUT_POWER_BITS  = 32;
    localparam int CFG_DATA_BITS   = 17;
    localparam int CFG_INDEX_BITS  = 2;

    localparam int GAIN_RESET      = 655;
    localparam int SETTLE_RESET    = 100;
    localparam int RATIO_RESET     = 512;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SMOOTHING_GAIN  = 2'd0,
        REG_SETTLE_SAMPLES  = 2'd1,
        REG_THRESHOLD_RATIO = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/rps_front.sv */
// Front end: takes sample requests and squares the I and Q parts.
module rps_front import rps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    input  q_status_t                  q_status,
    output logic                       push,
    output logic [2*SAMPLE_BITS-1:0]   push_power,
    output logic [SAMPLE_BITS-1:0]     push_i,
    output logic [SAMPLE_BITS-1:0]     push_q
);

    localparam int PW = 2*SAMPLE_BITS;

    logic                   s1_valid_reg, s1_valid_next;
    logic [PW-1:0]          sq_i_reg, sq_q_reg;
    logic [SAMPLE_BITS-1:0] samp_i_reg, samp_q_reg;
    logic                   advance, take;

    assign advance      = !s1_valid_reg || !q_status.full;
    assign sample_stall = !advance;
    assign take         = sample_valid && advance;
    assign push         = s1_valid_reg && !q_status.full;

    // Squares are never negative, so the sum fits the unsigned power word.
    assign push_power = sq_i_reg + sq_q_reg;
    assign push_i     = samp_i_reg;
    assign push_q     = samp_q_reg;

    assign s1_valid_next = take || (s1_valid_reg && q_status.full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Operands widened first so the full square survives.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sq_i_reg   <= $unsigned(PW'(sample_i) * PW'(sample_i));
            sq_q_reg   <= $unsigned(PW'(sample_q) * PW'(sample_q));
            samp_i_reg <= sample_i;
            samp_q_reg <= sample_q;
        end
    end

endmodule

/* rtl/rps_queue.sv */
// Short request queue between the front end and the smoother sequencer.
module rps_queue import rps_pkg::*; #(
    parameter int ENTRY_BITS = 4*SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ENTRY_BITS-1:0] wdata,
    input  logic                  pop,
    output logic [ENTRY_BITS-1:0] rdata,
    output q_status_t             status
);

    logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_BITS-1:0] rdata_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]    count_reg, count_next;

    assign status.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    // Head entry appears the cycle after the pop.
    assign rdata        = rdata_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

/* rtl/rps_back.sv */
// Back end: smoother, noise floor tracking, threshold and gating sequencer.
module rps_back import rps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = GAIN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    input  q_status_t                   q_status,
    input  logic [2*SAMPLE_BITS-1:0]    head_power,
    input  logic [SAMPLE_BITS-1:0]      head_i,
    input  logic [SAMPLE_BITS-1:0]      head_q,
    output logic                        pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [SAMPLE_BITS-1:0] gated_i,
    output logic signed [SAMPLE_BITS-1:0] gated_q,
    output logic                        burst_start_next,
    output logic                        burst_end_here,
    output logic [OUT_POWER_BITS-1:0]   smoothed_power
);

    localparam int PW           = 2*SAMPLE_BITS;
    localparam int HW           = SAMPLE_BITS;
    localparam int PROD_W       = HW + GAIN_BITS;
    localparam int STEP_FULL_W  = PW + GAIN_BITS;
    localparam int APROD_W      = HW + RATIO_BITS;
    localparam int ALERT_FULL_W = PW + RATIO_BITS;
    localparam int ALERT_W      = ALERT_FULL_W - RATIO_FRAC;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_LOAD  = 8'b00000010,
        ST_MUL   = 8'b00000100,
        ST_STEP  = 8'b00001000,
        ST_APPLY = 8'b00010000,
        ST_FLOOR = 8'b00100000,
        ST_SCALE = 8'b01000000,
        ST_EMIT  = 8'b10000000
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic [GAIN_BITS-1:0]    gain_reg, gain_next;
    logic [SETTLE_BITS-1:0]  settle_samples_reg, settle_samples_next;
    logic [RATIO_BITS-1:0]   ratio_reg, ratio_next;
    logic [PW-1:0]           avg_reg, avg_next;
    logic [PW-1:0]           floor_reg, floor_next;
    logic [SETTLE_BITS-1:0]  settle_left_reg, settle_left_next;
    logic                    passing_reg, passing_next;
    logic                    result_valid_reg, result_valid_next;

    // Working registers of the request in flight
    logic [PW-1:0]           diff_reg;
    logic                    up_reg;
    logic [PROD_W-1:0]       prod_hi_reg, prod_lo_reg;
    logic [PW-1:0]           step_reg;
    logic [APROD_W-1:0]      alert_hi_reg, alert_lo_reg;
    logic [SAMPLE_BITS-1:0]  samp_i_reg, samp_q_reg;

    logic [SAMPLE_BITS-1:0]  out_i_reg, out_q_reg;
    logic                    out_start_reg, out_end_reg;
    logic [PW-1:0]           out_power_reg;

    logic [STEP_FULL_W-1:0]  step_full;
    logic [ALERT_FULL_W-1:0] alert_full;
    logic                    above;
    logic                    emit_go;
    logic                    head_up;

    assign pop     = (state_reg == ST_IDLE) && !q_status.empty;
    assign head_up = head_power >= avg_reg;
    assign emit_go = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);

    // Recombine the split products; shifts drop the fraction (truncation).
    assign step_full  = {prod_hi_reg, HW'(0)} + STEP_FULL_W'(prod_lo_reg);
    assign alert_full = {alert_hi_reg, HW'(0)} + ALERT_FULL_W'(alert_lo_reg);
    assign above      = ALERT_W'(avg_reg) >= alert_full[ALERT_FULL_W-1:RATIO_FRAC];

    always_comb
    begin
        state_next          = state_reg;
        gain_next           = gain_reg;
        settle_samples_next = settle_samples_reg;
        ratio_next          = ratio_reg;
        avg_next            = avg_reg;
        floor_next          = floor_reg;
        settle_left_next    = settle_left_reg;
        passing_next        = passing_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_SMOOTHING_GAIN:
                begin
                    gain_next = GAIN_BITS'(cfg_data);
                end
                REG_SETTLE_SAMPLES:
                begin
                    settle_samples_next = cfg_data;
                    settle_left_next    = cfg_data;
                end
                REG_THRESHOLD_RATIO:
                begin
                    ratio_next = cfg_data[RATIO_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                avg_next   = up_reg ? (avg_reg + step_reg) : (avg_reg - step_reg);
                state_next = ST_FLOOR;
            end
            ST_FLOOR:
            begin
                if (settle_left_reg != '0)
                begin
                    settle_left_next = settle_left_reg - 1'b1;
                end
                else if (avg_reg < floor_reg)
                begin
                    floor_next = avg_reg;
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    passing_next = above;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid_next = emit_go || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            gain_reg           <= GAIN_BITS'(GAIN_RESET);
            settle_samples_reg <= SETTLE_BITS'(SETTLE_RESET);
            ratio_reg          <= RATIO_BITS'(RATIO_RESET);
            avg_reg            <= '0;
            floor_reg          <= PW'(1) << (PW - 2);
            settle_left_reg    <= SETTLE_BITS'(SETTLE_RESET);
            passing_reg        <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            gain_reg           <= gain_next;
            settle_samples_reg <= settle_samples_next;
            ratio_reg          <= ratio_next;
            avg_reg            <= avg_next;
            floor_reg          <= floor_next;
            settle_left_reg    <= settle_left_next;
            passing_reg        <= passing_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // head entry is valid the cycle after the pop
        if (state_reg == ST_LOAD)
        begin
            up_reg     <= head_up;
            diff_reg   <= head_up ? (head_power - avg_reg) : (avg_reg - head_power);
            samp_i_reg <= head_i;
            samp_q_reg <= head_q;
        end
        if (state_reg == ST_MUL)
        begin
            prod_hi_reg <= diff_reg[PW-1:HW] * gain_reg;
            prod_lo_reg <= diff_reg[HW-1:0] * gain_reg;
        end
        if (state_reg == ST_STEP)
        begin
            step_reg <= step_full[STEP_FULL_W-1:GAIN_BITS];
        end
        if (state_reg == ST_SCALE)
        begin
            alert_hi_reg <= floor_reg[PW-1:HW] * ratio_reg;
            alert_lo_reg <= floor_reg[HW-1:0] * ratio_reg;
        end
        if (emit_go)
        begin
            out_i_reg     <= passing_reg ? samp_i_reg : '0;
            out_q_reg     <= passing_reg ? samp_q_reg : '0;
            out_start_reg <= !passing_reg && above;
            out_end_reg   <= passing_reg && !above;
            out_power_reg <= avg_reg;
        end
    end

    assign result_valid     = result_valid_reg;
    assign gated_i          = $signed(out_i_reg);
    assign gated_q          = $signed(out_q_reg);
    assign burst_start_next = out_start_reg;
    assign burst_end_here   = out_end_reg;
    assign smoothed_power   = OUT_POWER_BITS'(out_power_reg);

endmodule

/* rtl/relative_power_squelch_top.sv */
// Top level of the relative power squelch: front end, request queue and back end.
//
// Relative power squelch with noise floor tracking. Each request is one complex
// sample; its power I*I+Q*Q feeds a single-pole smoother (gain alpha, Q0.16),
// and after settle_samples requests the lowest smoothed power becomes the noise
// floor (1.0 after reset). The alert level is floor times threshold_ratio
// (Q8.8). While squelched the result carries zeros and opens once the smoothed
// power reaches the alert level, flagging burst_start_next; while open the
// sample passes and the gate closes when power drops below the level, flagging
// burst_end_here. Every request gives exactly one result.
// Flow: the back-end sequencer takes each request through queue pop,
// difference, split gain multiply, step recombine, accumulate, floor update,
// split ratio multiply and decision, and pops no new request until that pass
// ends; a stall on the result side holds it at the decision. The front end
// registers the squared sample and a 4-entry queue holds waiting requests,
// so sample_stall rises only when that queue is full. The smoother state
// carries from one request to the next, so the passes do not overlap.
// Configuration writes are taken at any edge with cfg_write high but are meant
// for idle periods only; writing settle_samples restarts the settle count.
module relative_power_squelch_top import rps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = GAIN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] gated_i,
    output logic signed [SAMPLE_BITS-1:0] gated_q,
    output logic                          burst_start_next,
    output logic                          burst_end_here,
    output logic [OUT_POWER_BITS-1:0]     smoothed_power
);

`include "relative_power_squelch_top_defines.svh"

    localparam int PW         = 2*SAMPLE_BITS;
    localparam int ENTRY_BITS = PW + 2*SAMPLE_BITS;

    q_status_t              q_status;
    logic                   push, pop;
    logic [PW-1:0]          push_power;
    logic [SAMPLE_BITS-1:0] push_i, push_q;
    logic [ENTRY_BITS-1:0]  q_rdata;

    rps_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .q_status     (q_status),
        .push         (push),
        .push_power   (push_power),
        .push_i       (push_i),
        .push_q       (push_q)
    );

    // Queue entry: power word, then I, then Q.
    rps_queue #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({push_power, push_i, push_q}),
        .pop    (pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    rps_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .q_status         (q_status),
        .head_power       (q_rdata[ENTRY_BITS-1:2*SAMPLE_BITS]),
        .head_i           (q_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .head_q           (q_rdata[SAMPLE_BITS-1:0]),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .gated_i          (gated_i),
        .gated_q          (gated_q),
        .burst_start_next (burst_start_next),
        .burst_end_here   (burst_end_here),
        .smoothed_power   (smoothed_power)
    );

    // A gate cannot open and close on the same sample.
    `RPS_ASSERT_NOW(a_start_end_excl, result_valid, !(burst_start_next && burst_end_here))
    // Opening happens from the squelched state, so that sample is still muted.
    `RPS_ASSERT_NOW(a_start_muted, result_valid && burst_start_next, gated_i == '0 && gated_q == '0)
    // Queue never overruns or underruns.
    `RPS_ASSERT_NOW(a_no_overrun, q_status.full, !push)
    `RPS_ASSERT_NOW(a_no_underrun, q_status.empty, !pop)
    // Back end takes at most one request per sequencer pass.
    `RPS_ASSERT_NEXT(a_pop_spacing, pop, !pop)

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the relative power squelch: predictor, driver and monitor.
`timescale 1ns / 100ps

module tb_top;
    import rps_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int GB          = GAIN_BITS_DEF;
    localparam int NOISE_AMP   = 300;      // peak of the background noise, in LSBs
    localparam int HOLD_AT     = 450;      // result count at which the long hold-off starts
    localparam int HOLD_CYCLES = 300;      // length of that hold-off
    localparam int DRAIN_WAIT  = 20;       // quiet cycles after the last result
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;   // no register behind it

    // One request: a complex sample.
    typedef struct packed {
        logic signed [SB-1:0] i;
        logic signed [SB-1:0] q;
    } iq_t;

    // One result as the block should present it.
    typedef struct {
        logic signed [SB-1:0]      gi;
        logic signed [SB-1:0]      gq;
        logic                      start_next;
        logic                      end_here;
        logic [OUT_POWER_BITS-1:0] power;
    } gated_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    logic signed [SB-1:0]      sample_i = '0;
    logic signed [SB-1:0]      sample_q = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [SB-1:0]      gated_i;
    logic signed [SB-1:0]      gated_q;
    logic                      burst_start_next;
    logic                      burst_end_here;
    logic [OUT_POWER_BITS-1:0] smoothed_power;

    relative_power_squelch_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample_i         (sample_i),
        .sample_q         (sample_q),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .gated_i          (gated_i),
        .gated_q          (gated_q),
        .burst_start_next (burst_start_next),
        .burst_end_here   (burst_end_here),
        .smoothed_power   (smoothed_power)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the squelch state.
    // Wide vectors so the products never wrap; the block's outputs are
    // compared on their own widths.
    // ------------------------------------------------------------------
    logic [GB-1:0]          gain_reg;
    logic [RATIO_BITS-1:0]  ratio_reg;
    logic [63:0]            avg_power;
    logic [63:0]            floor_power;
    logic [63:0]            alert_power;
    logic [SETTLE_BITS-1:0] settle_count;
    logic                   gate_open;

    iq_t    request_backlog[$];    // requests not yet offered to the block
    gated_t gated_due_q[$];        // results predicted, not yet seen

    int requests_queued = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int starts_seen     = 0;
    int ends_seen       = 0;
    int reg_writes      = 0;
    int errors          = 0;
    int gap_pct         = 0;       // chance in percent of an idle burst, both sides

    // Register write as the block sees it; idle block only.
    task automatic apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_SMOOTHING_GAIN:
                gain_reg = value[GB-1:0];
            REG_SETTLE_SAMPLES:
                settle_count = value[SETTLE_BITS-1:0];
            REG_THRESHOLD_RATIO:
            begin
                ratio_reg   = value[RATIO_BITS-1:0];
                alert_power = (floor_power * ratio_reg) >> RATIO_FRAC;
            end
            default: ;
        endcase
    endtask

    // Advance the squelch by one sample and queue the result it gives.
    task automatic squelch_step(input logic signed [SB-1:0] si,
                                input logic signed [SB-1:0] sq);
        logic signed [63:0] wi;
        logic signed [63:0] wq;
        logic [63:0]        inst_power;
        gated_t             res;
        wi = si;
        wq = sq;
        inst_power = wi * wi + wq * wq;

        // smoother step truncated towards zero, both directions
        if (inst_power >= avg_power)
            avg_power = avg_power + (((inst_power - avg_power) * gain_reg) >> GB);
        else
            avg_power = avg_power - (((avg_power - inst_power) * gain_reg) >> GB);

        // floor only tracked once the settle count has run out
        if (settle_count != 0)
            settle_count = settle_count - 1'b1;
        else if (avg_power < floor_power)
        begin
            floor_power = avg_power;
            alert_power = (floor_power * ratio_reg) >> RATIO_FRAC;
        end

        res.start_next = 1'b0;
        res.end_here   = 1'b0;
        if (gate_open)
        begin
            res.gi = si;
            res.gq = sq;
            if (avg_power < alert_power)
            begin
                gate_open    = 1'b0;
                res.end_here = 1'b1;
            end
        end
        else
        begin
            res.gi = '0;
            res.gq = '0;
            if (avg_power >= alert_power)
            begin
                gate_open      = 1'b1;
                res.start_next = 1'b1;
            end
        end
        res.power = avg_power[OUT_POWER_BITS-1:0];
        gated_due_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers requests from the backlog. A new request (or an idle
    // burst) is only chosen once the current one has gone, so valid never
    // looks at stall and a stalled payload stays put.
    // ------------------------------------------------------------------
    int  send_gap = 0;
    iq_t next_req;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                squelch_step(sample_i, sample_q);
                requests_taken++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap == 0 && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                    send_gap = $urandom_range(1, 6);
                if (send_gap != 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    sample_valid <= 1'b1;
                    sample_i     <= next_req.i;
                    sample_q     <= next_req.q;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off on the result side, timed here in cycles; the monitor
    // keeps result_stall high while it runs.
    // ------------------------------------------------------------------
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && !hold_done && results_checked >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction and drives
    // result_stall: short random bursts, plus the long hold-off mid-run to
    // back the block up until it stalls its input.
    // ------------------------------------------------------------------
    int     stall_left = 0;
    gated_t want;

    task automatic check_field(input string label, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, label,
                     exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (burst_start_next === 1'b1)
                    starts_seen++;
                if (burst_end_here === 1'b1)
                    ends_seen++;
                if (gated_due_q.size() == 0)
                begin
                    $display("%0t ns: result with nothing outstanding, expected none, got %h %h",
                             $time, gated_i, gated_q);
                    errors++;
                end
                else
                begin
                    want = gated_due_q.pop_front();
                    check_field("gated_i", 32'(unsigned'(want.gi)), 32'(unsigned'(gated_i)));
                    check_field("gated_q", 32'(unsigned'(want.gq)), 32'(unsigned'(gated_q)));
                    check_field("burst_start_next", 32'(want.start_next),
                                32'(burst_start_next));
                    check_field("burst_end_here", 32'(want.end_here), 32'(burst_end_here));
                    check_field("smoothed_power", want.power, smoothed_power);
                end
            end

            if (hold_active)
            begin
                result_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                stall_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_iq(input int a, input int b);
        request_backlog.push_back('{i: a[SB-1:0], q: b[SB-1:0]});
        requests_queued++;
    endtask

    function automatic int noise_val();
        return int'($urandom_range(0, 2 * NOISE_AMP)) - NOISE_AMP;
    endfunction

    // Mostly well-formed traffic: runs of background noise and full-scale
    // bursts, with a few short spikes and lopsided samples thrown in.
    task automatic queue_bursty(input int count);
        int left;
        int run;
        int kind;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                run = $urandom_range(15, 70);
            else if (kind < 9)
                run = $urandom_range(8, 50);
            else
                run = $urandom_range(1, 8);
            if (run > left)
                run = left;
            repeat (run)
            begin
                if (kind < 5)
                    queue_iq(noise_val(), noise_val());
                else if (kind < 9)
                    queue_iq(int'($urandom), int'($urandom));
                else if ($urandom_range(0, 1) != 0)
                    queue_iq(int'($urandom), noise_val());
                else
                    queue_iq(noise_val(), int'($urandom));
            end
            left -= run;
        end
    endtask

    // Write one register; the predictor follows on the same edge.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_reg(idx, value);
        reg_writes++;
    endtask

    // Idle once every queued request is taken and every result is back.
    task automatic wait_drained();
        @(posedge clk);
        while (requests_taken != requests_queued || gated_due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int pct);
        gap_pct <= pct;
        queue_bursty(count);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // state after reset
        gain_reg     = GB'(GAIN_RESET);
        ratio_reg    = RATIO_BITS'(RATIO_RESET);
        avg_power    = '0;
        floor_power  = 64'd1 << (2 * (SB - 1));
        alert_power  = (floor_power * ratio_reg) >> RATIO_FRAC;
        settle_count = SETTLE_BITS'(SETTLE_RESET);
        gate_open    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // unknown index must leave everything alone
        write_reg(REG_SPARE, 17'h1_5A5A);

        // Directed: field extremes under the reset settings, still inside
        // the settle count, so the floor stays at 1.0.
        gap_pct <= 30;
        queue_iq(0, 0);
        queue_iq(32767, 32767);
        queue_iq(-32768, -32768);
        queue_iq(-32768, -32768);
        queue_iq(-32768, 32767);
        queue_iq(32767, -32768);
        queue_iq(-1, -1);
        queue_iq(1, 0);
        queue_iq(0, -1);
        queue_iq(-32768, 0);
        queue_iq(0, -32768);
        queue_iq(16384, -16384);
        queue_iq(21845, -21846);
        queue_iq(-21846, 21845);
        queue_iq(0, 0);
        queue_iq(0, 0);
        queue_iq(1, 1);
        queue_iq(32767, 0);
        queue_iq(0, 32767);
        queue_iq(-1, 0);
        wait_drained();

        // moderate smoothing, short settle, 4x threshold
        write_reg(REG_SMOOTHING_GAIN, 4096);
        write_reg(REG_SETTLE_SAMPLES, 30);
        write_reg(REG_THRESHOLD_RATIO, 1024);
        run_phase(300, 30);

        // reset-like settings, ratio just above one; long hold-off falls here
        write_reg(REG_THRESHOLD_RATIO, 257);
        write_reg(REG_SETTLE_SAMPLES, 100);
        write_reg(REG_SMOOTHING_GAIN, 655);
        run_phase(300, 20);

        // largest ratio, no idling on either side
        write_reg(REG_THRESHOLD_RATIO, 65535);
        run_phase(150, 0);

        // slowest non-zero smoothing, settle of one
        write_reg(REG_SMOOTHING_GAIN, 1);
        write_reg(REG_SETTLE_SAMPLES, 1);
        write_reg(REG_THRESHOLD_RATIO, 1023);
        run_phase(100, 40);

        // zero gain (upper data bit dropped): average frozen; settle of 65536
        write_reg(REG_SMOOTHING_GAIN, 17'h1_0000);
        write_reg(REG_SETTLE_SAMPLES, 17'h1_0000);
        run_phase(100, 25);

        // ratio of zero holds the gate open, then ratios of one and below
        write_reg(REG_SMOOTHING_GAIN, 2048);
        write_reg(REG_THRESHOLD_RATIO, 0);
        run_phase(60, 25);
        write_reg(REG_THRESHOLD_RATIO, 256);
        run_phase(80, 25);
        write_reg(REG_THRESHOLD_RATIO, 1);
        run_phase(70, 25);

        // fastest smoothing, floor frozen by a settle count of 65536
        write_reg(REG_SMOOTHING_GAIN, 65535);
        write_reg(REG_SETTLE_SAMPLES, 17'h1_0000);
        write_reg(REG_THRESHOLD_RATIO, 768);
        run_phase(250, 30);

        // final stretch: floor tracked at once, no idling at all
        write_reg(REG_SMOOTHING_GAIN, 8192);
        write_reg(REG_SETTLE_SAMPLES, 0);
        write_reg(REG_THRESHOLD_RATIO, 2000);
        run_phase(300, 0);

        // anything stray would show up in this window
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Squelch run: %0d samples, %0d results, %0d register writes",
                 requests_taken, results_checked, reg_writes);
        $display("Bursts seen: %0d openings, %0d closings, %0d mismatches",
                 starts_seen, ends_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
